// File: design/poly_voice_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the voice allocator
// ---------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ASSERT_SVH

// Check a consequent in the same cycle as the antecedent
`define PVA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after the antecedent
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pva_pkg.sv
// ---------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator.
// ---------------------------------------------------------------------------
package pva_pkg;

    localparam int VOICE_COUNT_DEF = 8;
    localparam int NOTE_W          = 7;
    localparam int OP_W            = 2;
    localparam int SEL_W           = 3;
    localparam int VOICE_W         = 3;
    localparam int MASK_W          = 8;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_FINISH   = 2'd3
    } t_op;

    // Steal priority class of a voice, lower is preferred
    typedef enum logic [1:0] {
        CLS_FREE,
        CLS_RELEASED,
        CLS_HELD
    } t_cls;

    typedef struct packed {
        logic              used;
        logic              gate;
        logic [NOTE_W-1:0] key;
    } t_flags;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_PLACE,
        ST_RELEASE,
        ST_FINISH,
        ST_DONE
    } t_state;

endpackage

// File: design/poly_voice_allocator.sv
// Sequence: a note on runs one scan to pick, then one scan to place and re-rank, then
// shows its result; note off and all notes off run one release scan; voice finished
// visits only the selected voice. Busy stays high through the strobe cycle, so the
// next item is taken only after the last result has been shown; no receiver stall.
// Synchronous active-low reset frees all voices, ranks voice zero oldest, clears mono.
// ---------------------------------------------------------------------------
// poly_voice_allocator
// Voice allocator with oldest-voice stealing (voice zero in mono mode), scanned one voice per cycle.
// ---------------------------------------------------------------------------
`include "poly_voice_allocator_assert.svh"

module poly_voice_allocator #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [pva_pkg::OP_W-1:0]     i_op,
    input  logic [pva_pkg::NOTE_W-1:0]   i_note,
    input  logic [pva_pkg::SEL_W-1:0]    i_voice_sel,
    output logic                         o_valid,
    output logic [pva_pkg::VOICE_W-1:0]  o_voice,
    output logic                         o_was_busy,
    output logic [pva_pkg::NOTE_W-1:0]   o_stolen_note,
    output logic [pva_pkg::MASK_W-1:0]   o_release_mask,
    output logic                         o_freed
);
    import pva_pkg::*;

    localparam int VW = $clog2(VOICE_COUNT);
    // Wide enough for any voice index, the value 8 and VOICE_COUNT itself
    localparam int XW = ((VW > SEL_W) ? VW : SEL_W) + 1;

    t_state              r_state;
    t_state              n_state;
    logic                r_mono;
    t_op                 r_op;
    logic [NOTE_W-1:0]   r_note;
    logic                r_sel_ok;
    logic [VW-1:0]       r_idx;
    logic [VOICE_W-1:0]  r_voice;
    logic                r_busy;
    logic [NOTE_W-1:0]   r_stolen;
    logic [MASK_W-1:0]   r_mask;
    logic                r_freed;

    logic                accept;
    logic                idx_last;
    logic [XW-1:0]       sel_w;
    logic [XW-1:0]       idx_w;
    t_flags              rd_flags;
    logic [VW-1:0]       rd_rank;
    t_flags              wr_flags;
    logic [VW-1:0]       wr_rank;
    logic                we;
    logic                pick_clear;
    logic                pick_en;
    logic [VW-1:0]       pick_idx;
    logic [VW-1:0]       pick_rank;
    logic                is_chosen;
    logic                rel_hit;
    logic                fin_hit;
    logic                on_done;
    logic                off_done;
    logic                on_clean;
    logic                off_clean;

    assign accept   = start && !busy;
    assign idx_last = (r_idx == VW'(VOICE_COUNT - 1));
    assign sel_w    = XW'(i_voice_sel);
    assign idx_w    = XW'(r_idx);

    pva_voice_file #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_file (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_idx      (r_idx),
        .i_we       (we),
        .i_wr_flags (wr_flags),
        .i_wr_rank  (wr_rank),
        .o_rd_flags (rd_flags),
        .o_rd_rank  (rd_rank)
    );

    pva_pick #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (pick_clear),
        .i_en    (pick_en),
        .i_mono  (r_mono),
        .i_idx   (r_idx),
        .i_flags (rd_flags),
        .i_rank  (rd_rank),
        .o_idx   (pick_idx),
        .o_rank  (pick_rank)
    );

    // Hold the mono mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono <= 1'b0;
        end else if (i_cfg_we) begin
            r_mono <= i_cfg_wdata;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_op'(i_op))
                        OP_NOTE_ON:  n_state = ST_PICK;
                        OP_NOTE_OFF: n_state = ST_RELEASE;
                        OP_ALL_OFF:  n_state = ST_RELEASE;
                        OP_FINISH:   n_state = ST_FINISH;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PICK: begin
                if (idx_last) n_state = ST_PLACE;
            end
            ST_PLACE: begin
                if (idx_last) n_state = ST_DONE;
            end
            ST_RELEASE: begin
                if (idx_last) n_state = ST_DONE;
            end
            ST_FINISH: n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-voice decisions on the scanned entry
    assign is_chosen = (r_idx == pick_idx);
    assign rel_hit   = rd_flags.used &&
                       ((r_op == OP_ALL_OFF) || (rd_flags.gate && (rd_flags.key == r_note)));
    assign fin_hit   = r_sel_ok && rd_flags.used && !rd_flags.gate;

    // Outputs of the sequencer: busy, result strobe, compare unit and voice file write controls
    always_comb begin
        busy       = (r_state != ST_IDLE);
        o_valid    = (r_state == ST_DONE);
        pick_clear = (r_state == ST_IDLE);
        pick_en    = (r_state == ST_PICK);
        we         = 1'b0;
        wr_flags   = rd_flags;
        wr_rank    = rd_rank;
        case (r_state)
            ST_PLACE: begin
                we = 1'b1;
                if (is_chosen) begin
                    wr_flags.used = 1'b1;
                    wr_flags.gate = 1'b1;
                    wr_flags.key  = r_note;
                    wr_rank       = VW'(VOICE_COUNT - 1);
                end else if (rd_rank > pick_rank) begin
                    wr_rank = rd_rank - VW'(1);
                end
            end
            ST_RELEASE: begin
                if (rel_hit) begin
                    we            = 1'b1;
                    wr_flags.gate = 1'b0;
                end
            end
            ST_FINISH: begin
                if (fin_hit) begin
                    we            = 1'b1;
                    wr_flags.used = 1'b0;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // Latch the item and advance the scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accept) begin
            r_idx <= (t_op'(i_op) == OP_FINISH) ? sel_w[VW-1:0] : '0;
        end else if ((r_state == ST_PICK) || (r_state == ST_PLACE) ||
                     (r_state == ST_RELEASE)) begin
            r_idx <= idx_last ? '0 : r_idx + VW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_op);
            r_note   <= i_note;
            r_sel_ok <= (sel_w < XW'(VOICE_COUNT));
        end
    end

    // Build the result as the scan goes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_voice  <= '0;
            r_busy   <= 1'b0;
            r_stolen <= '0;
            r_mask   <= '0;
            r_freed  <= 1'b0;
        end else begin
            if ((r_state == ST_PLACE) && is_chosen) begin
                r_voice  <= idx_w[VOICE_W-1:0];
                r_busy   <= rd_flags.used;
                r_stolen <= rd_flags.used ? rd_flags.key : '0;
            end
            if ((r_state == ST_RELEASE) && rel_hit && (idx_w < XW'(MASK_W))) begin
                r_mask <= r_mask | (MASK_W'(1) << idx_w[VOICE_W-1:0]);
            end
            if ((r_state == ST_FINISH) && fin_hit) begin
                r_freed <= 1'b1;
            end
        end
    end

    assign o_voice        = r_voice;
    assign o_was_busy     = r_busy;
    assign o_stolen_note  = r_stolen;
    assign o_release_mask = r_mask;
    assign o_freed        = r_freed;

    // Result classes checked below
    assign on_done   = o_valid && (r_op == OP_NOTE_ON);
    assign off_done  = o_valid && (r_op != OP_NOTE_ON);
    assign on_clean  = (o_release_mask == '0) && !o_freed;
    assign off_clean = (o_voice == '0) && !o_was_busy && (o_stolen_note == '0);

    `PVA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "item did not raise busy")
    `PVA_ASSERT_NEXT(a_strobe_once, i_clk, i_rst_n, o_valid, !o_valid && !busy, "long strobe")
    `PVA_ASSERT_SAME(a_noteon_clean, i_clk, i_rst_n, on_done, on_clean, "note on set release")
    `PVA_ASSERT_SAME(a_other_clean, i_clk, i_rst_n, off_done, off_clean, "stray voice fields")

endmodule

// File: design/pva_voice_file.sv
// ---------------------------------------------------------------------------
// pva_voice_file
// Per-voice flags, key and recency rank, one read/write port at the scan index.
// ---------------------------------------------------------------------------
module pva_voice_file #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF,
    localparam int VW = $clog2(VOICE_COUNT)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [VW-1:0]   i_idx,
    input  logic            i_we,
    input  pva_pkg::t_flags i_wr_flags,
    input  logic [VW-1:0]   i_wr_rank,
    output pva_pkg::t_flags o_rd_flags,
    output logic [VW-1:0]   o_rd_rank
);
    import pva_pkg::*;

    t_flags        r_flags [VOICE_COUNT];
    logic [VW-1:0] r_rank  [VOICE_COUNT];

    // Reset to all free, voice zero oldest; write the scanned voice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_flags[i] <= '0;
                r_rank[i]  <= VW'(i);
            end
        end else if (i_we) begin
            r_flags[i_idx] <= i_wr_flags;
            r_rank[i_idx]  <= i_wr_rank;
        end
    end

    // Read the scanned voice
    assign o_rd_flags = r_flags[i_idx];
    assign o_rd_rank  = r_rank[i_idx];

endmodule

// File: design/pva_pick.sv
// ---------------------------------------------------------------------------
// pva_pick
// Shared compare unit: keeps the best steal candidate seen during a scan.
// ---------------------------------------------------------------------------
module pva_pick #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF,
    localparam int VW = $clog2(VOICE_COUNT)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_en,
    input  logic            i_mono,
    input  logic [VW-1:0]   i_idx,
    input  pva_pkg::t_flags i_flags,
    input  logic [VW-1:0]   i_rank,
    output logic [VW-1:0]   o_idx,
    output logic [VW-1:0]   o_rank
);
    import pva_pkg::*;

    logic          r_found;
    t_cls          r_cls;
    logic [VW-1:0] r_idx;
    logic [VW-1:0] r_rank;
    t_cls          cls;
    logic          better;
    logic          take;

    // Classify the candidate: free first, then released, then held
    always_comb begin
        if (!i_flags.used) begin
            cls = CLS_FREE;
        end else if (!i_flags.gate) begin
            cls = CLS_RELEASED;
        end else begin
            cls = CLS_HELD;
        end
    end

    // Lowest free index wins; otherwise the oldest rank within the class.
    // In mono mode the first scanned voice (voice zero) is kept.
    assign better = (cls < r_cls) ||
                    ((cls == r_cls) && (cls != CLS_FREE) && (i_rank < r_rank));
    assign take   = !r_found || (!i_mono && better);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (i_en && take) begin
            r_found <= 1'b1;
        end
    end

    // Hold the candidate
    always_ff @(posedge i_clk) begin
        if (i_en && take) begin
            r_cls  <= cls;
            r_idx  <= i_idx;
            r_rank <= i_rank;
        end
    end

    assign o_idx  = r_idx;
    assign o_rank = r_rank;

endmodule
